FILE: hdl/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg
// Types and codes shared by the delta-list timer queue modules.
// ----------------------------------------------------------------------------
package dltq_pkg;

    // Item operation codes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_STOP    = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  timer_id;
        logic [15:0] timeout;
        logic        periodic;
    } item_t;

    typedef struct packed {
        logic        expired_valid;
        logic [3:0]  expired_id;
        logic [31:0] elapsed_ticks;
        logic        last;
    } result_t;

    // Datapath commands
    typedef enum logic [3:0] {
        DP_NONE        = 4'd0,
        DP_LATCH       = 4'd1,
        DP_HEAD_DEC    = 4'd2,
        DP_SEL_HEAD    = 4'd3,
        DP_RM0         = 4'd4,
        DP_RM1         = 4'd5,
        DP_RM2         = 4'd6,
        DP_SETUP       = 4'd7,
        DP_LOAD_RELOAD = 4'd8,
        DP_INS_INIT    = 4'd9,
        DP_INS_STEP    = 4'd10,
        DP_INS_LINK    = 4'd11,
        DP_INS_HEAD    = 4'd12,
        DP_EMIT        = 4'd13
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   last;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op_code;
        logic       tgt_valid;
        logic       tgt_active;
        logic       tgt_periodic;
        logic       head_expired;
        logic       walk_more;
        logic       pend;
        logic       out_free;
    } dp_status_t;

endpackage

FILE: hdl/delta_list_timer_queue.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Timer engine holding NUM_TIMERS timers in a relative-delay linked list.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid / item_stall / item) takes one word per
//   tick, start, restart or stop. The result channel (result_valid /
//   result_stall / result) returns one word per expired timer, in list
//   order, or a single word with expired_valid low; last marks the final
//   word of each item.
//   One item is worked at a time; item_stall stays high until its final
//   word is loaded into the result register. A start or restart walks the
//   list to insert the timer; an active timer is first unlinked, and a stop
//   only unlinks. A tick removes each expired timer from the list head, and
//   a periodic timer is walked back in with its reload value. The walk over
//   the linked list (one entry per cycle through a single table read port)
//   sets how long an insert takes.
//   Reset empties the list, clears all timers and the tick counter.
//   A stalled result holds the sequencer until the result register frees.
// ----------------------------------------------------------------------------
module delta_list_timer_queue #(
    parameter int NUM_TIMERS  = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  dltq_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output dltq_pkg::result_t result
);

    dltq_pkg::dp_cmd_t    cmd;
    dltq_pkg::dp_status_t status;

    // Sequencer: decode item, run unlink / insert / expiry steps
    dltq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // Tables, links, tick counter and result register
    dltq_datapath #(
        .NUM_TIMERS  (NUM_TIMERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Latch an item only on an accepted word
    a_latch_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == dltq_pkg::DP_LATCH) |-> (item_valid && !item_stall))
        else $error("item latched without handshake");

    // Never overwrite a result that is still held
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == dltq_pkg::DP_EMIT) |-> status.out_free)
        else $error("result register overwritten");

    // Busy after accepting an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("second item taken while busy");

endmodule

FILE: hdl/dltq_datapath.sv
// ----------------------------------------------------------------------------
// dltq_datapath
// Timer tables, delta list links, tick counter and result register.
// ----------------------------------------------------------------------------
module dltq_datapath #(
    parameter int NUM_TIMERS  = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dltq_pkg::item_t      item,
    input  dltq_pkg::dp_cmd_t    cmd,
    output dltq_pkg::dp_status_t status,
    output logic                 result_valid,
    input  logic                 result_stall,
    output dltq_pkg::result_t    result
);

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int LW = $clog2(NUM_TIMERS + 1);
    localparam int CW = COUNT_WIDTH;
    localparam logic [LW-1:0] NULL_LINK = LW'(NUM_TIMERS);

    logic [CW-1:0] delta_reg  [NUM_TIMERS];
    logic [LW-1:0] next_reg   [NUM_TIMERS];
    logic [LW-1:0] prev_reg   [NUM_TIMERS];
    logic [CW-1:0] reload_reg [NUM_TIMERS];
    logic          active_reg [NUM_TIMERS];
    logic          per_reg    [NUM_TIMERS];

    logic [LW-1:0] head_reg;
    logic [31:0]   tick_reg;
    logic [1:0]    op_reg;
    logic [LW-1:0] tgt_reg;
    logic [15:0]   tout_reg;
    logic          mode_reg;
    logic [LW-1:0] n_reg;
    logic [LW-1:0] p_reg;
    logic [CW-1:0] d_reg;
    logic [LW-1:0] cur_reg;
    logic [LW-1:0] before_reg;
    logic [CW-1:0] ticks_reg;
    logic          tgt_per_reg;
    logic          pend_reg;
    logic [LW-1:0] pend_id_reg;
    logic          out_valid_reg;
    dltq_pkg::result_t out_reg;

    logic [LW-1:0] rd_addr;
    logic [AW-1:0] rd_idx;
    logic          rd_valid;
    logic [CW-1:0] rd_delta;
    logic [LW-1:0] rd_next;
    logic [LW-1:0] rd_prev;
    logic [CW-1:0] rd_reload;
    logic          rd_per;
    logic [AW-1:0] tgt_idx;
    logic [AW-1:0] before_idx;
    logic          tgt_valid;
    logic          before_valid;
    logic          walk_more;
    logic          out_free;
    logic          id_ok;

    function automatic logic [CW-1:0] fix_tout(input logic [15:0] t);
        logic [32:0] wide;
        logic [32:0] lim;
        wide = 33'(t);
        lim  = (33'(1) << CW) - 33'(1);
        if (wide > lim)
            wide = lim;
        if (wide == 33'(0))
            wide = 33'(1);
        return wide[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] fix_count(input logic [CW-1:0] t);
        return (t == '0) ? CW'(1) : t;
    endfunction

    // Single read port, address chosen by command
    always_comb
    begin
        case (cmd.op) inside
            dltq_pkg::DP_RM1:      rd_addr = n_reg;
            dltq_pkg::DP_RM2:      rd_addr = p_reg;
            dltq_pkg::DP_INS_STEP: rd_addr = cur_reg;
            dltq_pkg::DP_NONE,
            dltq_pkg::DP_HEAD_DEC,
            dltq_pkg::DP_SEL_HEAD: rd_addr = head_reg;
            default:               rd_addr = tgt_reg;
        endcase
    end

    assign rd_idx       = rd_addr[AW-1:0];
    assign rd_valid     = (rd_addr < NULL_LINK);
    assign rd_delta     = rd_valid ? delta_reg[rd_idx]  : '0;
    assign rd_next      = rd_valid ? next_reg[rd_idx]   : NULL_LINK;
    assign rd_prev      = rd_valid ? prev_reg[rd_idx]   : NULL_LINK;
    assign rd_reload    = rd_valid ? reload_reg[rd_idx] : '0;
    assign rd_per       = rd_valid ? per_reg[rd_idx]    : 1'b0;
    assign tgt_idx      = tgt_reg[AW-1:0];
    assign tgt_valid    = (tgt_reg < NULL_LINK);
    assign before_idx   = before_reg[AW-1:0];
    assign before_valid = (before_reg < NULL_LINK);
    assign walk_more    = rd_valid && (rd_delta <= ticks_reg);
    assign out_free     = !out_valid_reg || !result_stall;
    assign id_ok        = (32'(item.timer_id) < 32'(NUM_TIMERS));

    always_comb
    begin
        status.op_code      = op_reg;
        status.tgt_valid    = tgt_valid;
        status.tgt_active   = tgt_valid ? active_reg[tgt_idx] : 1'b0;
        status.tgt_periodic = tgt_per_reg;
        status.head_expired = rd_valid && (rd_delta == '0);
        status.walk_more    = walk_more;
        status.pend         = pend_reg;
        status.out_free     = out_free;
    end

    // Tables and links
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                delta_reg[i]  <= '0;
                next_reg[i]   <= NULL_LINK;
                prev_reg[i]   <= NULL_LINK;
                reload_reg[i] <= '0;
                active_reg[i] <= 1'b0;
                per_reg[i]    <= 1'b0;
            end
            head_reg <= NULL_LINK;
        end
        else
        begin
            case (cmd.op)
                dltq_pkg::DP_HEAD_DEC:
                    if (rd_valid && rd_delta != '0)
                        delta_reg[rd_idx] <= rd_delta - CW'(1);
                dltq_pkg::DP_RM0:
                    if (rd_valid)
                    begin
                        active_reg[rd_idx] <= 1'b0;
                        next_reg[rd_idx]   <= NULL_LINK;
                        prev_reg[rd_idx]   <= NULL_LINK;
                    end
                dltq_pkg::DP_RM1:
                    if (rd_valid)
                    begin
                        delta_reg[rd_idx] <= rd_delta + d_reg;
                        prev_reg[rd_idx]  <= p_reg;
                    end
                dltq_pkg::DP_RM2:
                    if (rd_valid)
                        next_reg[rd_idx] <= n_reg;
                    else
                        head_reg <= n_reg;
                dltq_pkg::DP_SETUP:
                    if (rd_valid)
                    begin
                        reload_reg[rd_idx] <= fix_tout(tout_reg);
                        per_reg[rd_idx]    <= mode_reg;
                    end
                dltq_pkg::DP_INS_STEP:
                    if (rd_valid && !walk_more)
                    begin
                        delta_reg[rd_idx] <= rd_delta - ticks_reg;
                        prev_reg[rd_idx]  <= tgt_reg;
                    end
                dltq_pkg::DP_INS_LINK:
                    if (rd_valid)
                    begin
                        delta_reg[rd_idx]  <= ticks_reg;
                        prev_reg[rd_idx]   <= before_reg;
                        next_reg[rd_idx]   <= cur_reg;
                        active_reg[rd_idx] <= 1'b1;
                    end
                dltq_pkg::DP_INS_HEAD:
                    if (before_valid)
                        next_reg[before_idx] <= tgt_reg;
                    else
                        head_reg <= tgt_reg;
                default:
                    ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                dltq_pkg::DP_LATCH:
                begin
                    if (item.operation == dltq_pkg::OP_TICK)
                        tick_reg <= tick_reg + 32'd1;
                    pend_reg <= 1'b0;
                end
                dltq_pkg::DP_SEL_HEAD: pend_reg <= 1'b1;
                dltq_pkg::DP_EMIT:     pend_reg <= 1'b0;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            dltq_pkg::DP_LATCH:
            begin
                op_reg   <= item.operation;
                tgt_reg  <= id_ok ? LW'(item.timer_id) : NULL_LINK;
                tout_reg <= item.timeout;
                mode_reg <= item.periodic;
            end
            dltq_pkg::DP_SEL_HEAD:
            begin
                tgt_reg     <= head_reg;
                pend_id_reg <= head_reg;
            end
            dltq_pkg::DP_RM0:
            begin
                n_reg       <= rd_next;
                p_reg       <= rd_prev;
                d_reg       <= rd_delta;
                tgt_per_reg <= rd_per;
            end
            dltq_pkg::DP_SETUP:       ticks_reg <= fix_tout(tout_reg);
            dltq_pkg::DP_LOAD_RELOAD: ticks_reg <= fix_count(rd_reload);
            dltq_pkg::DP_INS_INIT:
            begin
                cur_reg    <= head_reg;
                before_reg <= NULL_LINK;
            end
            dltq_pkg::DP_INS_STEP:
                if (walk_more)
                begin
                    ticks_reg  <= ticks_reg - rd_delta;
                    before_reg <= cur_reg;
                    cur_reg    <= rd_next;
                end
            default:
                ;
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == dltq_pkg::DP_EMIT)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == dltq_pkg::DP_EMIT)
        begin
            out_reg.expired_valid <= pend_reg;
            out_reg.expired_id    <= pend_reg ? 4'(pend_id_reg) : 4'd0;
            out_reg.elapsed_ticks <= tick_reg;
            out_reg.last          <= cmd.last;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: hdl/dltq_ctrl.sv
// ----------------------------------------------------------------------------
// dltq_ctrl
// Sequencer for remove, insert and expiry steps of the timer queue.
// ----------------------------------------------------------------------------
module dltq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  dltq_pkg::dp_status_t status,
    output dltq_pkg::dp_cmd_t    cmd
);

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_DECODE   = 15'b000000000000010,
        S_TICK_DEC = 15'b000000000000100,
        S_CHECK    = 15'b000000000001000,
        S_EMIT_MID = 15'b000000000010000,
        S_RM0      = 15'b000000000100000,
        S_RM1      = 15'b000000001000000,
        S_RM2      = 15'b000000010000000,
        S_SETUP    = 15'b000000100000000,
        S_LOADR    = 15'b000001000000000,
        S_INS_INIT = 15'b000010000000000,
        S_INS_STEP = 15'b000100000000000,
        S_INS_LINK = 15'b001000000000000,
        S_INS_HEAD = 15'b010000000000000,
        S_FINAL    = 15'b100000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   is_tick;

    assign is_tick = (status.op_code == dltq_pkg::OP_TICK);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = dltq_pkg::DP_NONE;
        cmd.last   = 1'b0;
        item_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.op     = dltq_pkg::DP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
                if (is_tick)
                    state_next = S_TICK_DEC;
                else if (!status.tgt_valid)
                    state_next = S_FINAL;
                else if (status.tgt_active)
                    state_next = S_RM0;
                else if (status.op_code == dltq_pkg::OP_START)
                    state_next = S_SETUP;
                else if (status.op_code == dltq_pkg::OP_RESTART)
                    state_next = S_LOADR;
                else
                    state_next = S_FINAL;
            S_TICK_DEC:
            begin
                cmd.op     = dltq_pkg::DP_HEAD_DEC;
                state_next = S_CHECK;
            end
            S_CHECK:
                if (!status.head_expired)
                    state_next = S_FINAL;
                else if (status.pend)
                    state_next = S_EMIT_MID;
                else
                begin
                    cmd.op     = dltq_pkg::DP_SEL_HEAD;
                    state_next = S_RM0;
                end
            S_EMIT_MID:
                if (status.out_free)
                begin
                    cmd.op     = dltq_pkg::DP_EMIT;
                    state_next = S_CHECK;
                end
            S_RM0:
            begin
                cmd.op     = dltq_pkg::DP_RM0;
                state_next = S_RM1;
            end
            S_RM1:
            begin
                cmd.op     = dltq_pkg::DP_RM1;
                state_next = S_RM2;
            end
            S_RM2:
            begin
                cmd.op = dltq_pkg::DP_RM2;
                if (is_tick)
                    state_next = status.tgt_periodic ? S_LOADR : S_CHECK;
                else if (status.op_code == dltq_pkg::OP_START)
                    state_next = S_SETUP;
                else if (status.op_code == dltq_pkg::OP_RESTART)
                    state_next = S_LOADR;
                else
                    state_next = S_FINAL;
            end
            S_SETUP:
            begin
                cmd.op     = dltq_pkg::DP_SETUP;
                state_next = S_INS_INIT;
            end
            S_LOADR:
            begin
                cmd.op     = dltq_pkg::DP_LOAD_RELOAD;
                state_next = S_INS_INIT;
            end
            S_INS_INIT:
            begin
                cmd.op     = dltq_pkg::DP_INS_INIT;
                state_next = S_INS_STEP;
            end
            S_INS_STEP:
            begin
                cmd.op = dltq_pkg::DP_INS_STEP;
                if (!status.walk_more)
                    state_next = S_INS_LINK;
            end
            S_INS_LINK:
            begin
                cmd.op     = dltq_pkg::DP_INS_LINK;
                state_next = S_INS_HEAD;
            end
            S_INS_HEAD:
            begin
                cmd.op     = dltq_pkg::DP_INS_HEAD;
                state_next = is_tick ? S_CHECK : S_FINAL;
            end
            S_FINAL:
                if (status.out_free)
                begin
                    cmd.op     = dltq_pkg::DP_EMIT;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
